// ----- sv/tcit_pkg.sv -----
`timescale 1ns / 1ps

package tcit_pkg;

  localparam int MAX_COUNTERS = 3;

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_TICK  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  // Port 3 carries control words, ports 0 to 2 the counters' data
  localparam logic [1:0] CTRL_PORT = 2'd3;

  // Access field, control byte bits 5:4
  localparam logic [1:0] ACC_LATCH = 2'd0;
  localparam logic [1:0] ACC_LOW   = 2'd1;
  localparam logic [1:0] ACC_HIGH  = 2'd2;
  localparam logic [1:0] ACC_BOTH  = 2'd3;

  // Mode field, control byte bits 3:1
  localparam logic [2:0] MODE_TERM   = 3'd0;
  localparam logic [2:0] MODE_RATE   = 3'd2;
  localparam logic [2:0] MODE_SQUARE = 3'd3;

  typedef struct packed {
    op_t        op;
    logic [1:0] port_sel;
    logic [7:0] write_data;
  } req_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       irq_pulse;
    logic [2:0] out_levels;
  } rsp_t;

  // Per-counter command, at most one bit set
  typedef struct packed {
    logic       rd;
    logic       wr;
    logic       ctrl;
    logic       latch;
    logic       tick;
    logic [7:0] data;
  } chan_cmd_t;

  typedef struct packed {
    logic [7:0] rdata;
    logic       level;
    logic       rise;
  } chan_stat_t;

endpackage

// ----- sv/tcit_channel.sv -----
`timescale 1ns / 1ps

module tcit_channel (
  input  logic                  clk,
  input  logic                  rst,
  input  tcit_pkg::chan_cmd_t   cmd,
  output tcit_pkg::chan_stat_t  stat
);

  logic [7:0]  ctrl, ctrl_next;
  logic [15:0] count, count_next;
  logic [15:0] reload, reload_next;
  logic [15:0] latched, latched_next;
  logic        latch_valid, latch_valid_next;
  logic        toggle, toggle_next;
  logic        counting, counting_next;
  logic        level, level_next;

  logic [1:0]  acc;
  logic [2:0]  mode;
  logic [15:0] rd_src;
  logic [15:0] dec1;
  logic [15:0] sq_step;
  logic [15:0] sq_next;

  assign acc     = ctrl[5:4];
  assign mode    = ctrl[3:1];
  assign rd_src  = latch_valid ? latched : count;
  assign dec1    = count - 16'd1;
  assign sq_step = count[0] ? (level ? 16'd1 : 16'd3) : 16'd2;
  assign sq_next = count - sq_step;

  always_comb begin
    ctrl_next        = ctrl;
    count_next       = count;
    reload_next      = reload;
    latched_next     = latched;
    latch_valid_next = latch_valid;
    toggle_next      = toggle;
    counting_next    = counting;
    level_next       = level;
    stat.rdata       = 8'd0;
    stat.rise        = 1'b0;

    if (cmd.rd) begin
      if (latch_valid && (acc != tcit_pkg::ACC_BOTH || toggle)) begin
        latch_valid_next = 1'b0;
      end
      unique case (acc)
        tcit_pkg::ACC_LOW:  stat.rdata = rd_src[7:0];
        tcit_pkg::ACC_HIGH: stat.rdata = rd_src[15:8];
        tcit_pkg::ACC_BOTH: begin
          stat.rdata  = toggle ? rd_src[15:8] : rd_src[7:0];
          toggle_next = !toggle;
        end
        default:            stat.rdata = 8'd0;
      endcase
    end else if (cmd.wr) begin
      unique case (acc)
        tcit_pkg::ACC_LOW:  reload_next = {reload[15:8], cmd.data};
        tcit_pkg::ACC_HIGH: reload_next = {cmd.data, reload[7:0]};
        tcit_pkg::ACC_BOTH: begin
          reload_next = toggle ? {cmd.data, reload[7:0]} : {reload[15:8], cmd.data};
          toggle_next = !toggle;
        end
        default:            reload_next = reload;
      endcase
      // Load once the last byte of the access is in
      if (acc != tcit_pkg::ACC_BOTH || toggle) begin
        count_next    = reload_next;
        counting_next = 1'b1;
        level_next    = (mode == tcit_pkg::MODE_RATE) || (mode == tcit_pkg::MODE_SQUARE);
      end
    end else if (cmd.latch) begin
      latched_next     = count;
      latch_valid_next = 1'b1;
    end else if (cmd.ctrl) begin
      ctrl_next = cmd.data;
    end else if (cmd.tick && counting) begin
      unique case (mode)
        tcit_pkg::MODE_TERM: begin
          count_next = dec1;
          if (dec1 == 16'd0) begin
            level_next = 1'b1;
            stat.rise  = !level;
          end
        end
        tcit_pkg::MODE_RATE: begin
          if (dec1 == 16'd1) begin
            count_next = reload;
            level_next = 1'b0;
          end else begin
            count_next = dec1;
            level_next = 1'b1;
            stat.rise  = !level;
          end
        end
        tcit_pkg::MODE_SQUARE: begin
          if (sq_next == 16'd0) begin
            count_next = reload;
            level_next = !level;
            stat.rise  = !level;
          end else begin
            count_next = sq_next;
          end
        end
        default: ;  // hold
      endcase
    end

    // Report the level as it stands after this request
    stat.level = level_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl        <= 8'd0;
      count       <= 16'd0;
      reload      <= 16'd0;
      latched     <= 16'd0;
      latch_valid <= 1'b0;
      toggle      <= 1'b0;
      counting    <= 1'b0;
      level       <= 1'b0;
    end else begin
      ctrl        <= ctrl_next;
      count       <= count_next;
      reload      <= reload_next;
      latched     <= latched_next;
      latch_valid <= latch_valid_next;
      toggle      <= toggle_next;
      counting    <= counting_next;
      level       <= level_next;
    end
  end

endmodule

// ----- sv/three_channel_interval_timer_unit.sv -----
`timescale 1ns / 1ps

// Interval timer with up to three 16-bit down counters behind four byte ports.
// Each request is a port read, a port write or one timer tick, and gives
// exactly one response: the byte read, an IRQ pulse when counter 0's output
// rises on a tick, and the output levels of all counters. A request is held in
// the input register while the counters update and the response is formed,
// and the response is then registered; a new request is taken every cycle
// while the response side keeps up. Counters at or above NUM_COUNTERS are
// absent: their ports read as zero and writes to them are dropped.
module three_channel_interval_timer_unit #(
  parameter int NUM_COUNTERS = 3
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_stall,
  input  tcit_pkg::req_t  req,
  output logic            rsp_valid,
  input  logic            rsp_stall,
  output tcit_pkg::rsp_t  rsp
);

  localparam logic [2:0] NUM_W = 3'(NUM_COUNTERS);

  tcit_pkg::req_t     req_q;
  logic               req_q_valid;
  logic               advance;
  tcit_pkg::chan_cmd_t cmd [tcit_pkg::MAX_COUNTERS];
  tcit_pkg::chan_stat_t stat [tcit_pkg::MAX_COUNTERS];
  logic [7:0]         rdata_all;
  logic [2:0]         levels;
  tcit_pkg::rsp_t     rsp_next;
  logic [1:0]         ctrl_sel;
  logic               ctrl_is_latch;

  assign advance   = req_q_valid && (!rsp_valid || !rsp_stall);
  assign req_stall = req_q_valid && !advance;

  assign ctrl_sel      = req_q.write_data[7:6];
  assign ctrl_is_latch = req_q.write_data[5:4] == tcit_pkg::ACC_LATCH;

  for (genvar i = 0; i < tcit_pkg::MAX_COUNTERS; i++) begin : g_chan
    if (i < NUM_COUNTERS) begin : g_on
      always_comb begin
        cmd[i].data  = req_q.write_data;
        cmd[i].rd    = advance && req_q.op == tcit_pkg::OP_READ && req_q.port_sel == 2'(i);
        cmd[i].wr    = advance && req_q.op == tcit_pkg::OP_WRITE && req_q.port_sel == 2'(i);
        cmd[i].latch = advance && req_q.op == tcit_pkg::OP_WRITE
                       && req_q.port_sel == tcit_pkg::CTRL_PORT
                       && ctrl_sel == 2'(i) && ctrl_is_latch;
        cmd[i].ctrl  = advance && req_q.op == tcit_pkg::OP_WRITE
                       && req_q.port_sel == tcit_pkg::CTRL_PORT
                       && ctrl_sel == 2'(i) && !ctrl_is_latch;
        cmd[i].tick  = advance && req_q.op == tcit_pkg::OP_TICK;
      end

      tcit_channel u_chan (
        .clk  (clk),
        .rst  (rst),
        .cmd  (cmd[i]),
        .stat (stat[i])
      );
    end else begin : g_off
      assign stat[i] = '0;
    end
  end

  always_comb begin
    rdata_all = 8'd0;
    for (int i = 0; i < tcit_pkg::MAX_COUNTERS; i++) begin
      rdata_all = rdata_all | stat[i].rdata;
      levels[i] = stat[i].level;
    end
  end

  // Levels after the request: take what the counters are about to hold
  always_comb begin
    rsp_next.read_data  = rdata_all;
    rsp_next.irq_pulse  = (req_q.op == tcit_pkg::OP_TICK) && stat[0].rise;
    rsp_next.out_levels = levels;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      req_q_valid <= 1'b0;
      rsp_valid   <= 1'b0;
    end else begin
      if (!req_stall) begin
        req_q_valid <= req_valid;
      end
      if (advance) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!req_stall && req_valid) begin
      req_q <= req;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rsp <= rsp_next;
    end
  end

  a_irq_only_on_tick: assert property (@(posedge clk) disable iff (rst)
    advance && req_q.op != tcit_pkg::OP_TICK |=> !rsp.irq_pulse)
    else $error("irq pulse without a tick");

  a_irq_level_high: assert property (@(posedge clk) disable iff (rst)
    advance |=> (!rsp.irq_pulse || rsp.out_levels[0]))
    else $error("irq pulse while counter 0 output is low");

  a_read_data_zero: assert property (@(posedge clk) disable iff (rst)
    advance && req_q.op != tcit_pkg::OP_READ |=> rsp.read_data == 8'd0)
    else $error("read data on a non-read request");

  a_stall_needs_item: assert property (@(posedge clk) disable iff (rst)
    req_stall |-> req_q_valid && rsp_valid)
    else $error("input stalled with nothing held");

  a_absent_levels: assert property (@(posedge clk) disable iff (rst)
    (NUM_W < 3'd3) |-> !levels[2])
    else $error("absent counter drives a level");

endmodule
